// File: design/lom_pkg.sv
// Shared types, field widths and codes for the limit order matcher.
// No dependencies.
`default_nettype none
package lom_pkg;

  localparam int TRD_W   = 3;
  localparam int OID_W   = 10;
  localparam int PRD_W   = 4;
  localparam int QTY_W   = 20;
  localparam int VAL_W   = 40;
  localparam int FEE_W   = 34;
  localparam int TOT_W   = 48;
  localparam int NID_W   = 11;
  localparam int KIND_W  = 3;
  localparam int IN_W    = 64;
  localparam int OUT_W   = 152;
  localparam int CFG_AW  = 1;
  localparam int CFG_DW  = 5;
  localparam int RES_W   = 6;
  localparam int MAX_RES = 32;
  localparam int NID_N   = 8;

  localparam int DEF_ORDER_SLOTS = 32;
  localparam int DEF_PRODUCTS    = 16;
  localparam int DEF_TRADERS     = 8;

  localparam logic [QTY_W-1:0] QTY_MAX = 20'd999999;
  localparam int               FEE_DIV = 100;

  localparam logic [1:0] REQ_BUY    = 2'd0;
  localparam logic [1:0] REQ_SELL   = 2'd1;
  localparam logic [1:0] REQ_AMEND  = 2'd2;
  localparam logic [1:0] REQ_CANCEL = 2'd3;

  localparam logic [KIND_W-1:0] KIND_ACCEPTED  = 3'd0;
  localparam logic [KIND_W-1:0] KIND_AMENDED   = 3'd1;
  localparam logic [KIND_W-1:0] KIND_CANCELLED = 3'd2;
  localparam logic [KIND_W-1:0] KIND_INVALID   = 3'd3;
  localparam logic [KIND_W-1:0] KIND_FILL      = 3'd4;

  localparam logic [1:0] ST_ACTIVE    = 2'd1;
  localparam logic [1:0] ST_FILLED    = 2'd2;
  localparam logic [1:0] ST_CANCELLED = 2'd3;

  localparam logic SIDE_BUY  = 1'b0;
  localparam logic SIDE_SELL = 1'b1;

  localparam logic MODE_FIND = 1'b0;
  localparam logic MODE_BEST = 1'b1;

  localparam logic [CFG_AW-1:0] REG_PRODUCT_COUNT = 1'd0;
  localparam logic [CFG_AW-1:0] REG_TRADER_COUNT  = 1'd1;

  typedef struct packed {
    logic [TRD_W-1:0] trader;
    logic [OID_W-1:0] oid;
    logic [PRD_W-1:0] product;
    logic [QTY_W-1:0] qty;
    logic [QTY_W-1:0] price;
    logic             side;
    logic [1:0]       status;
  } slot_t;

  typedef struct packed {
    logic  found;
    slot_t slot;
  } link_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [OID_W-1:0]  echo;
    logic [TRD_W-1:0]  bt;
    logic [OID_W-1:0]  bo;
    logic [TRD_W-1:0]  st;
    logic [OID_W-1:0]  so;
    logic [QTY_W-1:0]  qty;
    logic [QTY_W-1:0]  price;
    logic [VAL_W-1:0]  value;
    logic [FEE_W-1:0]  fee;
  } res_t;

  function automatic logic in_range(input logic [QTY_W-1:0] v);
    return (v != '0) && (v <= QTY_MAX);
  endfunction

endpackage
`default_nettype wire

// File: design/lom_cell.sv
// One book slot of the matcher chain plus its stage of the search pipeline.
// Depends on lom_pkg.
`default_nettype none
module lom_cell import lom_pkg::*; #(
  parameter int ORDER_SLOTS = DEF_ORDER_SLOTS,
  parameter int IDX         = 0,
  localparam int SLOT_W     = $clog2(ORDER_SLOTS),
  localparam int CNT_W      = $clog2(ORDER_SLOTS + 1)
) (
  input  wire              clk,
  input  wire              rst,
  input  wire              wr_en,
  input  wire [SLOT_W-1:0] wr_idx,
  input  slot_t            wr_slot,
  input  wire              mode,
  input  slot_t            key,
  input  wire [SLOT_W-1:0] key_idx,
  input  wire [CNT_W-1:0]  ecount,
  input  link_t            lin,
  input  wire [SLOT_W-1:0] lin_idx,
  output link_t            lout,
  output logic [SLOT_W-1:0] lout_idx
);

  localparam logic [SLOT_W-1:0] MY  = SLOT_W'(IDX);
  localparam logic [CNT_W-1:0]  MYC = CNT_W'(IDX);

  slot_t slot;
  logic  act, find_hit, px_ok, best_hit, hit;

  always_comb begin
    act      = (MYC < ecount) && (slot.status == ST_ACTIVE);
    find_hit = act && !lin.found && (slot.trader == key.trader) && (slot.oid == key.oid);
    if (key.side == SIDE_BUY) begin
      px_ok = (slot.price <= key.price) && (!lin.found || slot.price < lin.slot.price);
    end else begin
      px_ok = (slot.price >= key.price) && (!lin.found || slot.price > lin.slot.price);
    end
    best_hit = act && (MY != key_idx) && (slot.side != key.side) &&
               (slot.product == key.product) && px_ok;
    hit = (mode == MODE_FIND) ? find_hit : best_hit;
  end

  always_ff @(posedge clk) begin
    if (wr_en && wr_idx == MY) begin
      slot <= wr_slot;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lout.found <= 1'b0;
    end else begin
      lout.found <= hit | lin.found;
    end
    lout.slot <= hit ? slot : lin.slot;
    lout_idx  <= hit ? MY : lin_idx;
  end

endmodule
`default_nettype wire

// File: design/lom_fee_div.sv
// Fee divider: splits the dividend into halves and finishes with a reciprocal multiply.
// Start is registered into stage, then into done. Depends on lom_pkg.
`default_nettype none
module lom_fee_div import lom_pkg::*; (
  input  wire              clk,
  input  wire              rst,
  input  wire              start,
  input  wire [VAL_W-1:0]  dividend,
  output logic             done,
  output logic [FEE_W-1:0] quotient
);

  // dividend = hi * 2^20 + lo; 2^20 = HI_SCALE * FEE_DIV + HI_REM
  localparam int HALF_W = VAL_W / 2;
  localparam int NRM_W  = 27;
  localparam int RCP_W  = 28;
  localparam int RCP_SH = 34;
  localparam int PRD_FW = NRM_W + RCP_W;
  localparam logic [FEE_W-1:0] HI_SCALE = FEE_W'((1 << HALF_W) / FEE_DIV);
  localparam logic [NRM_W-1:0] HI_REM   = NRM_W'((1 << HALF_W) % FEE_DIV);
  localparam longint RCP_L = ((longint'(1) << RCP_SH) + longint'(FEE_DIV) - 1) /
                             longint'(FEE_DIV);
  localparam logic [RCP_W-1:0] RCP = RCP_W'(RCP_L);

  logic [HALF_W-1:0] hi, lo;
  logic [FEE_W-1:0]  hq;
  logic [NRM_W-1:0]  nrm;
  logic [PRD_FW-1:0] prd;
  logic              stage;

  always_comb begin
    hi  = dividend[VAL_W-1:HALF_W];
    lo  = dividend[HALF_W-1:0];
    prd = PRD_FW'(nrm) * PRD_FW'(RCP);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage <= 1'b0;
      done  <= 1'b0;
    end else begin
      stage <= start;
      done  <= stage;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      hq  <= FEE_W'(hi) * HI_SCALE;
      nrm <= NRM_W'(hi) * HI_REM + NRM_W'(lo);
    end
    if (stage) begin
      quotient <= hq + FEE_W'(prd >> RCP_SH);
    end
  end

endmodule
`default_nettype wire

// File: design/limit_order_matcher_core.sv
// Top level of the limit order matcher: request sequencer, slot chain, fee unit.
// Depends on lom_pkg, lom_cell and lom_fee_div.
// One request is taken at a time. Buy and sell are validated in S_CHECK;
// amend and cancel first search the slot chain for their order. Every fill
// then costs one search of the chain, a multiply, the fee launch and the
// two-stage divider, and the write-back states S_PUSH and S_WINC, plus any
// stall on the output. A final search that finds no counter order leads to
// S_FIN, where the last beat is sent before the input is ready again. A beat
// is launched only after the previous one has left. Results of a request
// leave one beat each, the status first, then the fills, tlast on the final
// one. The book needs no clearing after reset.
`default_nettype none
module limit_order_matcher_core import lom_pkg::*; #(
  parameter int ORDER_SLOTS = DEF_ORDER_SLOTS,
  parameter int PRODUCTS    = DEF_PRODUCTS,
  parameter int TRADERS     = DEF_TRADERS
) (
  input  wire              clk,
  input  wire              rst,
  input  wire              cfg_we,
  input  wire [CFG_AW-1:0] cfg_addr,
  input  wire [CFG_DW-1:0] cfg_data,
  input  wire              s_tvalid,
  output logic             s_tready,
  // req_type[1:0] trader[4:2] order_ref[14:5] product[18:15] quantity[38:19]
  // price[58:39]
  input  wire [IN_W-1:0]   s_tdata,
  output logic             m_tvalid,
  input  wire              m_tready,
  // echo_order[9:0] buyer_trader[12:10] buyer_order[22:13] seller_trader[25:23]
  // seller_order[35:26] fill_qty[55:36] fill_price[75:56] trade_value[115:76]
  // fee[149:116]
  output logic [OUT_W-1:0] m_tdata,
  // result_kind[2:0]
  output logic [KIND_W-1:0] m_tuser,
  output logic             m_tlast
);

  localparam int SLOT_W = $clog2(ORDER_SLOTS);
  localparam int CNT_W  = $clog2(ORDER_SLOTS + 1);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_CHECK = 4'd1;
  localparam logic [3:0] S_FIND  = 4'd2;
  localparam logic [3:0] S_SCAN  = 4'd3;
  localparam logic [3:0] S_MUL   = 4'd4;
  localparam logic [3:0] S_DIVGO = 4'd5;
  localparam logic [3:0] S_DIV   = 4'd6;
  localparam logic [3:0] S_PUSH  = 4'd7;
  localparam logic [3:0] S_WINC  = 4'd8;
  localparam logic [3:0] S_FIN   = 4'd9;

  logic [3:0]        state;
  logic [1:0]        r_type;
  logic [TRD_W-1:0]  r_trader;
  logic [OID_W-1:0]  r_oref;
  logic [PRD_W-1:0]  r_prod;
  logic [QTY_W-1:0]  r_qty, r_price;
  logic [NID_W-1:0]  nid [NID_N];
  logic [CNT_W-1:0]  ecount;
  logic [TOT_W-1:0]  fee_total;
  logic [CFG_DW-1:0] prod_count;
  logic [3:0]        trad_count;
  logic              mode;
  slot_t             inc;
  logic [SLOT_W-1:0] inc_idx;
  logic [CNT_W-1:0]  cnt;
  logic [RES_W-1:0]  k;
  res_t              pend, outr;
  logic [QTY_W-1:0]  fq, fp;
  slot_t             bslot;
  logic [SLOT_W-1:0] bidx;
  logic [VAL_W-1:0]  value;
  logic [FEE_W-1:0]  fee;

  link_t             lk [ORDER_SLOTS+1];
  logic [SLOT_W-1:0] lki [ORDER_SLOTS+1];

  logic              wr_en;
  logic [SLOT_W-1:0] wr_idx;
  slot_t             wr_slot;

  logic              div_done;
  logic [FEE_W-1:0]  div_q;

  logic [8:0] prod_lim, trad_lim;
  logic       trader_ok, new_ok, scan_end;
  slot_t      new_slot, fnd_slot, rest_slot;
  res_t       fill_res, stat_res;

  assign lk[0]  = '0;
  assign lki[0] = '0;

  for (genvar i = 0; i < ORDER_SLOTS; i++) begin : g_cell
    lom_cell #(.ORDER_SLOTS(ORDER_SLOTS), .IDX(i)) u_cell (
      .clk      (clk),
      .rst      (rst),
      .wr_en    (wr_en),
      .wr_idx   (wr_idx),
      .wr_slot  (wr_slot),
      .mode     (mode),
      .key      (inc),
      .key_idx  (inc_idx),
      .ecount   (ecount),
      .lin      (lk[i]),
      .lin_idx  (lki[i]),
      .lout     (lk[i+1]),
      .lout_idx (lki[i+1])
    );
  end

  lom_fee_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (state == S_DIVGO),
    .dividend (value + VAL_W'(FEE_DIV / 2)),
    .done     (div_done),
    .quotient (div_q)
  );

  always_comb begin
    prod_lim  = ({4'b0, prod_count} < 9'(PRODUCTS)) ? {4'b0, prod_count} : 9'(PRODUCTS);
    trad_lim  = ({5'b0, trad_count} < 9'(TRADERS)) ? {5'b0, trad_count} : 9'(TRADERS);
    trader_ok = ({6'b0, r_trader} < trad_lim);
    new_ok    = trader_ok && ({5'b0, r_prod} < prod_lim) && in_range(r_qty) &&
                in_range(r_price) && (nid[r_trader] == {1'b0, r_oref}) &&
                (ecount < CNT_W'(ORDER_SLOTS));
    scan_end  = (cnt == CNT_W'(ORDER_SLOTS));

    stat_res      = '0;
    stat_res.echo = r_oref;
    stat_res.kind = (new_ok && (r_type == REQ_BUY || r_type == REQ_SELL)) ?
                    KIND_ACCEPTED : KIND_INVALID;

    new_slot         = '0;
    new_slot.trader  = r_trader;
    new_slot.oid     = r_oref;
    new_slot.product = r_prod;
    new_slot.qty     = r_qty;
    new_slot.price   = r_price;
    new_slot.side    = (r_type == REQ_BUY) ? SIDE_BUY : SIDE_SELL;
    new_slot.status  = ST_ACTIVE;

    fnd_slot = lk[ORDER_SLOTS].slot;
    if (r_type == REQ_AMEND) begin
      fnd_slot.qty   = r_qty;
      fnd_slot.price = r_price;
    end else begin
      fnd_slot.qty    = '0;
      fnd_slot.price  = '0;
      fnd_slot.status = ST_CANCELLED;
    end

    rest_slot     = bslot;
    rest_slot.qty = bslot.qty - fq;
    if (rest_slot.qty == '0) begin
      rest_slot.status = ST_FILLED;
    end

    fill_res       = '0;
    fill_res.kind  = KIND_FILL;
    fill_res.bt    = (inc.side == SIDE_BUY) ? inc.trader : bslot.trader;
    fill_res.bo    = (inc.side == SIDE_BUY) ? inc.oid : bslot.oid;
    fill_res.st    = (inc.side == SIDE_BUY) ? bslot.trader : inc.trader;
    fill_res.so    = (inc.side == SIDE_BUY) ? bslot.oid : inc.oid;
    fill_res.qty   = fq;
    fill_res.price = fp;
    fill_res.value = value;
    fill_res.fee   = fee;

    wr_en   = 1'b0;
    wr_idx  = ecount[SLOT_W-1:0];
    wr_slot = new_slot;
    case (state)
      S_CHECK: begin
        wr_en = (r_type == REQ_BUY || r_type == REQ_SELL) && new_ok;
      end
      S_FIND: begin
        wr_en   = scan_end && lk[ORDER_SLOTS].found &&
                  (r_type == REQ_CANCEL || (in_range(r_qty) && in_range(r_price)));
        wr_idx  = lki[ORDER_SLOTS];
        wr_slot = fnd_slot;
      end
      S_PUSH: begin
        wr_en   = !m_tvalid;
        wr_idx  = bidx;
        wr_slot = rest_slot;
      end
      S_WINC: begin
        wr_en   = 1'b1;
        wr_idx  = inc_idx;
        wr_slot = inc;
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  assign s_tready = (state == S_IDLE);
  assign m_tuser  = outr.kind;
  assign m_tdata  = {2'b0, outr.fee, outr.value, outr.price, outr.qty, outr.so, outr.st,
                     outr.bo, outr.bt, outr.echo};

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      ecount     <= '0;
      fee_total  <= '0;
      prod_count <= CFG_DW'(16);
      trad_count <= 4'd8;
      m_tvalid   <= 1'b0;
      m_tlast    <= 1'b0;
      cnt        <= '0;
      k          <= '0;
      mode       <= MODE_FIND;
      for (int i = 0; i < NID_N; i++) begin
        nid[i] <= '0;
      end
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          REG_PRODUCT_COUNT: prod_count <= cfg_data;
          REG_TRADER_COUNT:  trad_count <= cfg_data[3:0];
          default:           prod_count <= prod_count;
        endcase
      end
      if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      if ((state == S_SCAN || state == S_FIND) && !scan_end) begin
        cnt <= cnt + 1'b1;
      end

      case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            r_type   <= s_tdata[1:0];
            r_trader <= s_tdata[4:2];
            r_oref   <= s_tdata[14:5];
            r_prod   <= s_tdata[18:15];
            r_qty    <= s_tdata[38:19];
            r_price  <= s_tdata[58:39];
            state    <= S_CHECK;
          end
        end
        S_CHECK: begin
          pend <= stat_res;
          k    <= RES_W'(1);
          if (new_ok && (r_type == REQ_BUY || r_type == REQ_SELL)) begin
            inc           <= new_slot;
            inc_idx       <= ecount[SLOT_W-1:0];
            ecount        <= ecount + 1'b1;
            nid[r_trader] <= nid[r_trader] + 1'b1;
            mode          <= MODE_BEST;
            cnt           <= '0;
            state         <= S_SCAN;
          end else if (trader_ok && (r_type == REQ_AMEND || r_type == REQ_CANCEL)) begin
            inc.trader <= r_trader;
            inc.oid    <= r_oref;
            mode       <= MODE_FIND;
            cnt        <= '0;
            state      <= S_FIND;
          end else begin
            state <= S_FIN;
          end
        end
        S_FIND: begin
          if (scan_end) begin
            if (wr_en && r_type == REQ_AMEND) begin
              pend.kind <= KIND_AMENDED;
              inc       <= fnd_slot;
              inc_idx   <= lki[ORDER_SLOTS];
              mode      <= MODE_BEST;
              cnt       <= '0;
              state     <= S_SCAN;
            end else begin
              if (wr_en) begin
                pend.kind <= KIND_CANCELLED;
              end
              state <= S_FIN;
            end
          end
        end
        S_SCAN: begin
          if (scan_end) begin
            if (lk[ORDER_SLOTS].found) begin
              bslot <= lk[ORDER_SLOTS].slot;
              bidx  <= lki[ORDER_SLOTS];
              fp    <= lk[ORDER_SLOTS].slot.price;
              fq    <= (lk[ORDER_SLOTS].slot.qty < inc.qty) ? lk[ORDER_SLOTS].slot.qty
                                                            : inc.qty;
              state <= S_MUL;
            end else begin
              state <= S_FIN;
            end
          end
        end
        S_MUL: begin
          value <= VAL_W'(fq * fp);
          state <= S_DIVGO;
        end
        S_DIVGO: begin
          state <= S_DIV;
        end
        S_DIV: begin
          if (div_done) begin
            fee   <= div_q;
            state <= S_PUSH;
          end
        end
        S_PUSH: begin
          if (!m_tvalid) begin
            outr      <= pend;
            m_tlast   <= 1'b0;
            m_tvalid  <= 1'b1;
            pend      <= fill_res;
            inc.qty   <= inc.qty - fq;
            if (inc.qty == fq) begin
              inc.status <= ST_FILLED;
            end
            fee_total <= fee_total + TOT_W'(fee);
            k         <= k + 1'b1;
            state     <= S_WINC;
          end
        end
        S_WINC: begin
          if (inc.qty != '0 && k < RES_W'(MAX_RES)) begin
            cnt   <= '0;
            state <= S_SCAN;
          end else begin
            state <= S_FIN;
          end
        end
        S_FIN: begin
          if (!m_tvalid) begin
            outr     <= pend;
            m_tlast  <= 1'b1;
            m_tvalid <= 1'b1;
            state    <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

// File: design/lom_checker.sv
// Port-level checks for the matcher and the bind that attaches them.
// Depends on lom_pkg and limit_order_matcher_core.
`default_nettype none
module lom_checker import lom_pkg::*; (
  input wire              clk,
  input wire              rst,
  input wire              s_tvalid,
  input wire              s_tready,
  input wire [IN_W-1:0]   s_tdata,
  input wire              m_tvalid,
  input wire              m_tready,
  input wire [OUT_W-1:0]  m_tdata,
  input wire [KIND_W-1:0] m_tuser,
  input wire              m_tlast
);

  // stalled beat stays up
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("output beat dropped while stalled");

  // one request at a time
  a_one: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("request taken while busy");

  a_status: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser != KIND_FILL |-> m_tdata[149:10] == '0)
    else $error("status beat carries fill data");

  a_fill: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == KIND_FILL |-> m_tdata[9:0] == '0 && m_tdata[55:36] != '0)
    else $error("bad fill beat");

endmodule

bind limit_order_matcher_core lom_checker u_lom_checker (.*);
`default_nettype wire
